// ===== sv/mfd_pkg.sv =====
// shared constants and types for the multiplexed frame deframer
`default_nettype none
package mfd_pkg;

	localparam logic [7:0] START_BYTE    = 8'hBF;
	localparam logic [7:0] INVERT_MASK   = 8'hFF;
	localparam logic [7:0] MAX_DATA_LINK = 8'd8;

	localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
	localparam logic [1:0] KIND_GOOD     = 2'd1;
	localparam logic [1:0] KIND_BAD      = 2'd2;
	localparam logic [1:0] KIND_OVERFLOW = 2'd3;

	localparam logic REG_MAX_PAYLOAD  = 1'b0;
	localparam logic REG_CTRL_LINK_ID = 1'b1;

	localparam logic [15:0] MAX_PAYLOAD_RST  = 16'd1024;
	localparam logic [7:0]  CTRL_LINK_ID_RST = 8'd255;

	typedef struct packed {
		logic [15:0] byte_index;
		logic [15:0] frame_length;
		logic [7:0]  frame_link;
		logic [7:0]  data_byte;
	} res_data_t;

	typedef struct packed {
		logic [1:0] kind;
		res_data_t  data;
	} res_t;

endpackage
`default_nettype wire

// ===== sv/mux_frame_deframer_core.sv =====
// top level of the multiplexed frame deframer: framing state, apb registers, output stage
// a result is registered in the output register, or in the skid while the output stalls
// throughput: one request per cycle unless skid full; framing state updates in the accept cycle
// a two-entry output stage (output register plus skid) keeps s_tready high while one result waits
// reset: asynchronous, active low; hunts for a start byte, registers take their defaults
`default_nettype none
module mux_frame_deframer_core
	import mfd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // rx_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,   // data_byte, frame_link, frame_length, byte_index
	output logic [1:0]       m_tuser,   // kind
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam logic [2:0] PH_HUNT   = 3'd0;
	localparam logic [2:0] PH_LINK   = 3'd1;
	localparam logic [2:0] PH_LEN_HI = 3'd2;
	localparam logic [2:0] PH_LEN_LO = 3'd3;
	localparam logic [2:0] PH_DATA   = 3'd4;
	localparam logic [2:0] PH_CHECK  = 3'd5;

	logic [15:0] max_payload_q;
	logic [7:0]  ctrl_link_id_q;
	logic [2:0]  phase_q, phase_d;
	logic [7:0]  held_link_q, held_link_d;
	logic [15:0] held_length_q, held_length_d;
	logic [15:0] payload_count_q, payload_count_d;
	logic [15:0] count_inc;
	logic        in_acc, cfg_wr, out_free;
	logic        res_v;
	res_t        res;
	logic        out_v_q, skid_v_q;
	res_t        out_q, skid_q;

	// apb registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		unique case (paddr[2])
			REG_MAX_PAYLOAD:  prdata = {16'd0, max_payload_q};
			REG_CTRL_LINK_ID: prdata = {24'd0, ctrl_link_id_q};
			default:          prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q  <= MAX_PAYLOAD_RST;
			ctrl_link_id_q <= CTRL_LINK_ID_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_MAX_PAYLOAD) begin
				max_payload_q <= pwdata[15:0];
			end else begin
				ctrl_link_id_q <= pwdata[7:0];
			end
		end
	end

	// framing state
	assign s_tready  = !skid_v_q;
	assign in_acc    = s_tvalid && s_tready;
	assign count_inc = payload_count_q + 16'd1;

	always_comb begin
		phase_d         = phase_q;
		held_link_d     = held_link_q;
		held_length_d   = held_length_q;
		payload_count_d = payload_count_q;
		res_v           = 1'b0;
		res.kind                = KIND_PAYLOAD;
		res.data.data_byte      = 8'd0;
		res.data.frame_link     = held_link_q;
		res.data.frame_length   = held_length_q;
		res.data.byte_index     = payload_count_q;
		unique case (phase_q)
			PH_HUNT: begin
				if (s_tdata == START_BYTE) begin
					phase_d = PH_LINK;
				end
			end
			PH_LINK: begin
				if (s_tdata <= MAX_DATA_LINK || s_tdata == ctrl_link_id_q) begin
					held_link_d = s_tdata;
					phase_d     = PH_LEN_HI;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_LEN_HI: begin
				held_length_d = {s_tdata, 8'd0};
				phase_d       = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				held_length_d   = {held_length_q[15:8], held_length_q[7:0] | s_tdata};
				payload_count_d = 16'd0;
				phase_d         = (held_length_d == 16'd0) ? PH_CHECK : PH_DATA;
			end
			PH_DATA: begin
				res_v = 1'b1;
				if (payload_count_q < max_payload_q) begin
					res.data.data_byte = s_tdata;
					payload_count_d    = count_inc;
					if (count_inc == held_length_q) begin
						phase_d = PH_CHECK;
					end
				end else begin
					res.kind        = KIND_OVERFLOW;
					phase_d         = PH_HUNT;
					payload_count_d = 16'd0;
				end
			end
			PH_CHECK: begin
				res_v           = 1'b1;
				res.kind        = ((s_tdata ^ INVERT_MASK) == held_link_q) ? KIND_GOOD : KIND_BAD;
				phase_d         = PH_HUNT;
				payload_count_d = 16'd0;
			end
			default: begin
				phase_d         = PH_HUNT;
				payload_count_d = 16'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_HUNT;
			held_link_q     <= 8'd0;
			held_length_q   <= 16'd0;
			payload_count_q <= 16'd0;
		end else if (in_acc) begin
			phase_q         <= phase_d;
			held_link_q     <= held_link_d;
			held_length_q   <= held_length_d;
			payload_count_q <= payload_count_d;
		end
	end

	// output register and skid
	assign out_free = !out_v_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_free) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= in_acc && res_v;
			end
		end else if (in_acc && res_v) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_v_q ? skid_q : res;
		end else if (in_acc && res_v) begin
			skid_q <= res;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q.data;
	assign m_tuser  = out_q.kind;

endmodule
`default_nettype wire

// ===== sv/mfd_checker.sv =====
// port-level checks for the multiplexed frame deframer, bound to the top level
`default_nettype none
module mfd_checker
	import mfd_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [47:0] m_tdata,
	input wire logic [1:0]  m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_index_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_PAYLOAD |-> m_tdata[47:32] < m_tdata[31:16])
		else $error("payload index beyond declared length");

	a_status_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != KIND_PAYLOAD |-> m_tdata[7:0] == 8'd0)
		else $error("status result carries a data byte");

	a_check_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_GOOD || m_tuser == KIND_BAD)
		|-> m_tdata[47:32] == m_tdata[31:16])
		else $error("frame status with short payload count");

endmodule

bind mux_frame_deframer_core mfd_checker u_mfd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire

// ===== tb/sv/mux_frame_deframer_core_tb.sv =====
// self-checking testbench for the multiplexed frame deframer core
`default_nettype none
module mux_frame_deframer_core_tb;
	import mfd_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 120;
	localparam int NUM_PHASES  = 5;
	localparam int DIR_ROWS    = 27;
	localparam int DIR_SPLIT   = 21;
	localparam logic [2:0] ADDR_MAX_PAYLOAD  = {REG_MAX_PAYLOAD, 2'b00};
	localparam logic [2:0] ADDR_CTRL_LINK_ID = {REG_CTRL_LINK_ID, 2'b00};

	typedef enum logic [2:0] {
		PH_HUNT, PH_LINK, PH_LEN_HI, PH_LEN_LO, PH_PAYLOAD, PH_CHECK
	} deframe_phase_e;

	typedef struct packed {
		logic [7:0]  rx;
		logic        typed;
		logic [1:0]  kind;
		logic [7:0]  dbyte;
		logic [7:0]  link;
		logic [15:0] len;
		logic [15:0] idx;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;   // data_byte, frame_link, frame_length, byte_index
	logic [1:0]  m_tuser;   // kind
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	mux_frame_deframer_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor state and register mirror
	deframe_phase_e fr_phase = PH_HUNT;
	logic [7:0]  fr_link  = '0;
	logic [15:0] fr_len   = '0;
	logic [15:0] fr_count = '0;
	logic [15:0] cfg_max  = MAX_PAYLOAD_RST;
	logic [7:0]  cfg_ctrl = CTRL_LINK_ID_RST;

	res_t pending_res[$];
	int   err_count = 0;
	int   items_sent = 0;
	int   results_seen = 0;
	int   kind_seen [4] = '{0, 0, 0, 0};
	int   cyc_count = 0;
	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;

	dir_row_t dir_rows [DIR_ROWS] = '{
		'{8'h00, 1'b0, KIND_PAYLOAD,  8'h00, 8'h00, 16'h0000, 16'h0000},
		'{8'hBF, 1'b0, KIND_PAYLOAD,  8'h00, 8'h00, 16'h0000, 16'h0000},
		'{8'h08, 1'b0, KIND_PAYLOAD,  8'h00, 8'h00, 16'h0000, 16'h0000},
		'{8'h00, 1'b0, KIND_PAYLOAD,  8'h00, 8'h00, 16'h0000, 16'h0000},
		'{8'h02, 1'b0, KIND_PAYLOAD,  8'h00, 8'h00, 16'h0000, 16'h0000},
		'{8'hFF, 1'b1, KIND_PAYLOAD,  8'hFF, 8'h08, 16'h0002, 16'h0000},
		'{8'h00, 1'b1, KIND_PAYLOAD,  8'h00, 8'h08, 16'h0002, 16'h0001},
		'{8'hF7, 1'b1, KIND_GOOD,     8'h00, 8'h08, 16'h0002, 16'h0002},
		'{8'hBF, 1'b0, KIND_PAYLOAD,  8'h00, 8'h00, 16'h0000, 16'h0000},
		'{8'hFF, 1'b0, KIND_PAYLOAD,  8'h00, 8'h00, 16'h0000, 16'h0000},
		'{8'h00, 1'b0, KIND_PAYLOAD,  8'h00, 8'h00, 16'h0000, 16'h0000},
		'{8'h00, 1'b0, KIND_PAYLOAD,  8'h00, 8'h00, 16'h0000, 16'h0000},
		'{8'h00, 1'b1, KIND_GOOD,     8'h00, 8'hFF, 16'h0000, 16'h0000},
		'{8'hBF, 1'b0, KIND_PAYLOAD,  8'h00, 8'h00, 16'h0000, 16'h0000},
		'{8'h09, 1'b0, KIND_PAYLOAD,  8'h00, 8'h00, 16'h0000, 16'h0000},
		'{8'hBF, 1'b0, KIND_PAYLOAD,  8'h00, 8'h00, 16'h0000, 16'h0000},
		'{8'h00, 1'b0, KIND_PAYLOAD,  8'h00, 8'h00, 16'h0000, 16'h0000},
		'{8'h00, 1'b0, KIND_PAYLOAD,  8'h00, 8'h00, 16'h0000, 16'h0000},
		'{8'h01, 1'b0, KIND_PAYLOAD,  8'h00, 8'h00, 16'h0000, 16'h0000},
		'{8'h5A, 1'b1, KIND_PAYLOAD,  8'h5A, 8'h00, 16'h0001, 16'h0000},
		'{8'h00, 1'b1, KIND_BAD,      8'h00, 8'h00, 16'h0001, 16'h0001},
		// with max_payload at zero
		'{8'hBF, 1'b0, KIND_PAYLOAD,  8'h00, 8'h00, 16'h0000, 16'h0000},
		'{8'h01, 1'b0, KIND_PAYLOAD,  8'h00, 8'h00, 16'h0000, 16'h0000},
		'{8'hFF, 1'b0, KIND_PAYLOAD,  8'h00, 8'h00, 16'h0000, 16'h0000},
		'{8'hFF, 1'b0, KIND_PAYLOAD,  8'h00, 8'h00, 16'h0000, 16'h0000},
		'{8'h11, 1'b1, KIND_OVERFLOW, 8'h00, 8'h01, 16'hFFFF, 16'h0000},
		'{8'h3C, 1'b0, KIND_PAYLOAD,  8'h00, 8'h00, 16'h0000, 16'h0000}
	};

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (err_count < 40)
			$display("mismatch %s: got %0h want %0h (cycle %0d)", what, got, want, cyc_count);
		err_count++;
	endtask

	task automatic deframe_byte(input logic [7:0] b, output logic has_res, output res_t r);
		has_res = 1'b0;
		r = '0;
		case (fr_phase)
			PH_HUNT: begin
				if (b == START_BYTE)
					fr_phase = PH_LINK;
			end
			PH_LINK: begin
				if (b <= MAX_DATA_LINK || b == cfg_ctrl) begin
					fr_link = b;
					fr_phase = PH_LEN_HI;
				end else begin
					fr_phase = PH_HUNT;
				end
			end
			PH_LEN_HI: begin
				fr_len = {b, 8'h00};
				fr_phase = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				fr_len = {fr_len[15:8], b};
				fr_count = '0;
				fr_phase = (fr_len == 16'd0) ? PH_CHECK : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				has_res = 1'b1;
				r.data.byte_index = fr_count;
				if (fr_count < cfg_max) begin
					r.kind = KIND_PAYLOAD;
					r.data.data_byte = b;
					fr_count = fr_count + 16'd1;
					if (fr_count == fr_len)
						fr_phase = PH_CHECK;
				end else begin
					r.kind = KIND_OVERFLOW;
					fr_phase = PH_HUNT;
					fr_count = '0;
				end
			end
			PH_CHECK: begin
				has_res = 1'b1;
				r.data.byte_index = fr_count;
				r.kind = ((b ^ INVERT_MASK) == fr_link) ? KIND_GOOD : KIND_BAD;
				fr_phase = PH_HUNT;
				fr_count = '0;
			end
			default: begin
				fr_phase = PH_HUNT;
				fr_count = '0;
			end
		endcase
		r.data.frame_link = fr_link;
		r.data.frame_length = fr_len;
	endtask

	// drives one request, leaves s_tvalid high at the accepting edge
	task automatic push_rx(input logic [7:0] b, input logic typed = 1'b0,
			input res_t typed_res = '0);
		logic has_res;
		res_t r;
		if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'($urandom);
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(negedge clk); while (!s_tready);
		deframe_byte(b, has_res, r);
		if (typed)
			pending_res.push_back(typed_res);
		else if (has_res)
			pending_res.push_back(r);
		items_sent++;
		@(posedge clk);
	endtask

	task automatic run_row(input int i);
		res_t want;
		want.kind = dir_rows[i].kind;
		want.data.data_byte = dir_rows[i].dbyte;
		want.data.frame_link = dir_rows[i].link;
		want.data.frame_length = dir_rows[i].len;
		want.data.byte_index = dir_rows[i].idx;
		push_rx(dir_rows[i].rx, dir_rows[i].typed, want);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (addr == ADDR_MAX_PAYLOAD)
			cfg_max = data[15:0];
		else if (addr == ADDR_CTRL_LINK_ID)
			cfg_ctrl = data[7:0];
	endtask

	task automatic apb_read(input logic [2:0] addr, input logic [31:0] want);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		if (pready && prdata !== want)
			report_mismatch("register readback", 64'(prdata), 64'(want));
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_config(input logic [15:0] max_pl, input logic [7:0] ctrl);
		logic [31:0] w;
		s_tvalid <= 1'b0;
		while (pending_res.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		w = $urandom;
		w[15:0] = max_pl;
		apb_write(ADDR_MAX_PAYLOAD, w);
		w = $urandom;
		w[7:0] = ctrl;
		apb_write(ADDR_CTRL_LINK_ID, w);
		apb_read(ADDR_MAX_PAYLOAD, {16'h0, cfg_max});
		apb_read(ADDR_CTRL_LINK_ID, {24'h0, cfg_ctrl});
	endtask

	// mostly well-formed frames with random content, the rest noise and cut-off frames
	task automatic stream_frames(input int n_items);
		int start_cnt;
		int len;
		int nbytes;
		logic [7:0] link;
		logic [7:0] chk;
		start_cnt = items_sent;
		while (items_sent - start_cnt < n_items) begin
			if ($urandom_range(0, 9) < 2) begin
				repeat ($urandom_range(1, 4)) push_rx(8'($urandom));
			end else begin
				push_rx(START_BYTE);
				case ($urandom_range(0, 9))
					0: link = 8'($urandom);
					1: link = cfg_ctrl;
					default: link = 8'($urandom_range(0, MAX_DATA_LINK));
				endcase
				push_rx(link);
				case ($urandom_range(0, 9))
					0: len = (cfg_max <= 16) ? int'($urandom_range(0, 65535)) : 0;
					1: len = (cfg_max <= 16) ? int'(cfg_max) + 1 : 1;
					default: len = $urandom_range(0, 12);
				endcase
				push_rx(8'(len >> 8));
				push_rx(8'(len));
				nbytes = (len > int'(cfg_max)) ? int'(cfg_max) + 1 : len;
				if ($urandom_range(0, 19) == 0)
					nbytes = $urandom_range(0, nbytes);
				repeat (nbytes) push_rx(8'($urandom));
				if (len <= int'(cfg_max)) begin
					chk = link ^ INVERT_MASK;
					if ($urandom_range(0, 3) == 0)
						chk = 8'($urandom);
					push_rx(chk);
				end
			end
		end
	endtask

	initial begin
		m_tready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	always @(negedge clk) begin : check_results
		res_t want;
		res_data_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_res.size() == 0) begin
				report_mismatch("result with none pending", 64'({m_tuser, m_tdata}), '0);
			end else begin
				want = pending_res.pop_front();
				if (m_tuser !== want.kind)
					report_mismatch("kind", 64'(m_tuser), 64'(want.kind));
				if (got.data_byte !== want.data.data_byte)
					report_mismatch("data_byte", 64'(got.data_byte),
						64'(want.data.data_byte));
				if (got.frame_link !== want.data.frame_link)
					report_mismatch("frame_link", 64'(got.frame_link),
						64'(want.data.frame_link));
				if (got.frame_length !== want.data.frame_length)
					report_mismatch("frame_length", 64'(got.frame_length),
						64'(want.data.frame_length));
				if (got.byte_index !== want.data.byte_index)
					report_mismatch("byte_index", 64'(got.byte_index),
						64'(want.data.byte_index));
				kind_seen[want.kind]++;
			end
			results_seen++;
		end
	end

	always @(posedge clk) begin
		cyc_count <= cyc_count + 1;
		if (cyc_count == CYCLE_LIMIT) begin
			$display("timeout with %0d results pending", pending_res.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin : stimulus
		logic [15:0] phase_max [NUM_PHASES];
		logic [7:0]  phase_ctrl [NUM_PHASES];
		int          phase_send [NUM_PHASES];
		int          phase_stall [NUM_PHASES];
		phase_max   = '{16'd4, 16'd65535, 16'd0, 16'd12, 16'd0};
		phase_ctrl  = '{8'd0, 8'd255, 8'd200, 8'd8, 8'd0};
		phase_send  = '{25, 0, 30, 10, 0};
		phase_stall = '{25, 30, 0, 10, 0};
		phase_max[NUM_PHASES-1] = 16'($urandom_range(0, 20));
		phase_ctrl[NUM_PHASES-1] = 8'($urandom);
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apb_read(ADDR_MAX_PAYLOAD, {16'h0, MAX_PAYLOAD_RST});
		apb_read(ADDR_CTRL_LINK_ID, {24'h0, CTRL_LINK_ID_RST});

		send_idle_pct = 20;
		recv_stall_pct = 20;
		for (int i = 0; i < DIR_SPLIT; i++)
			run_row(i);
		set_config(16'd0, CTRL_LINK_ID_RST);
		for (int i = DIR_SPLIT; i < DIR_ROWS; i++)
			run_row(i);

		for (int p = 0; p < NUM_PHASES; p++) begin
			set_config(phase_max[p], phase_ctrl[p]);
			send_idle_pct = phase_send[p];
			recv_stall_pct = phase_stall[p];
			stream_frames(PHASE_ITEMS);
		end
		s_tvalid <= 1'b0;

		while (pending_res.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("%0d bytes sent over %0d register settings, %0d results checked",
			items_sent, NUM_PHASES + 2, results_seen);
		$display("payload %0d, good %0d, check failed %0d, overflow %0d",
			kind_seen[KIND_PAYLOAD], kind_seen[KIND_GOOD], kind_seen[KIND_BAD],
			kind_seen[KIND_OVERFLOW]);
		if (err_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
`default_nettype wire
